[rtl/core/pve3d_pkg.sv]
// Shared types and constants for the 3D position/velocity estimator.
package pve3d_pkg;
	localparam int POS_BITS   = 24;
	localparam int STAMP_BITS = 48;
	localparam int DIFF_BITS  = POS_BITS + 1;
	localparam int NUM_BITS   = DIFF_BITS + 10;
	localparam int SUM_BITS   = 66;
	localparam int ROOT_BITS  = SUM_BITS / 2;
	localparam int CNT_BITS   = 7;
	localparam logic [9:0] SEC_MS = 10'd1000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_SQ, ST_ROOT1, ST_DIV, ST_VSQ, ST_ROOT2, ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic [SUM_BITS-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic done;
		logic [ROOT_BITS-1:0] root;
	} sqrt_rsp_t;
endpackage

[rtl/core/pve3d_sqrt.sv]
// Iterative rounded integer square root, one result bit per cycle.
module pve3d_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  pve3d_pkg::sqrt_req_t req,
	output pve3d_pkg::sqrt_rsp_t rsp
);
	import pve3d_pkg::*;

	logic [SUM_BITS-1:0]  s_q;
	logic [SUM_BITS+1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [5:0]           cnt_q;
	logic                 busy_q, round_q, done_q;
	logic [SUM_BITS+1:0]  rem_sh, trial;
	logic [SUM_BITS-1:0]  s_sh;

	always_comb begin
		rem_sh = {rem_q[SUM_BITS-1:0], s_q[SUM_BITS-1 -: 2]};
		s_sh   = {s_q[SUM_BITS-3:0], 2'b00};
		trial  = {{(SUM_BITS-ROOT_BITS){1'b0}}, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				round_q <= 1'b0;
				s_q     <= req.radicand;
				rem_q   <= '0;
				root_q  <= '0;
				cnt_q   <= 6'(ROOT_BITS - 1);
			end else if (busy_q) begin
				s_q <= s_sh;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q  <= 1'b0;
					round_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end else if (round_q) begin
				// round to nearest: remainder above root adds one
				if (rem_q > (SUM_BITS+2)'(root_q)) root_q <= root_q + ROOT_BITS'(1);
				round_q <= 1'b0;
				done_q  <= 1'b1;
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.root = root_q;
	end
endmodule

[rtl/core/position_velocity_estimator_3d_top.sv]
// Top level of the 3D position/velocity estimator.
//
// Usage:
//   s_axis carries one item: tuser = func (1 = clear history), tdata holds
//   pos_x, pos_y, pos_z, stamp. m_axis returns exactly one result per item:
//   tuser = valid_res, tdata holds out_x/y/z, elapsed, displacement,
//   vel_x/y/z, speed.
//   A clear or a first / non-increasing update: the result is valid the
//   cycle after acceptance; with a ready receiver the next item can be
//   accepted once that result has been taken.
//   A motion update passes through: the difference step, the squares, a
//   pass of the shared square-root unit (33 digit steps, one rounding
//   step, one hand-off), three restoring divides (35 steps plus one
//   round/saturate step), the velocity squares, a second square-root pass
//   and the output step. One shared 32x32 multiplier forms all squares.
//   s_axis_tready is high only while idle with no result waiting; the block
//   holds one item at a time. A stalled receiver keeps the result in the
//   output register and s_axis_tready low.
//   Reset clears the history (no previous fix) and drops any result.
module position_velocity_estimator_3d_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], stamp[119:72]
	input  logic [119:0] s_axis_tdata,
	// tuser: func[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: out_x[23:0], out_y[47:24], out_z[71:48], elapsed[103:72],
	//        displacement[128:104], vel_x[160:129], vel_y[192:161],
	//        vel_z[224:193], speed[256:225], zero fill [263:257]
	output logic [263:0] m_axis_tdata,
	// tuser: valid_res[0]
	output logic         m_axis_tuser
);
	import pve3d_pkg::*;

	state_t state_q, state_d;

	logic                    has_prev_q;
	logic signed [POS_BITS-1:0] last_x_q, last_y_q, last_z_q;
	logic [STAMP_BITS-1:0]   last_stamp_q;
	logic signed [POS_BITS-1:0] x_q, y_q, z_q;
	logic [STAMP_BITS-1:0]   dt_q;
	logic [DIFF_BITS-1:0]    mag_q [3];
	logic [2:0]              neg_q;
	logic [1:0]              ax_q;
	logic [SUM_BITS-1:0]     acc_q;
	logic [24:0]             disp_q;
	logic [31:0]             vel_q [3];
	logic [31:0]             vmag_q [3];
	logic [31:0]             spd_q;
	logic [CNT_BITS-1:0]     cnt_q;

	// shared sqrt
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	// shared divider
	logic [NUM_BITS-1:0]  dv_num_q;
	logic [STAMP_BITS:0]  dv_rem_q;
	logic [NUM_BITS-1:0]  dv_quo_q;

	logic [63:0]          prod;
	logic [STAMP_BITS:0]  dv_rem_sh;
	logic [DIFF_BITS-1:0] mag_sel;
	logic [31:0]          vm_sel;
	logic [NUM_BITS:0]    q_rnd;
	logic [STAMP_BITS:0]  twice_rem;
	logic [31:0]          vel_sat;
	logic signed [POS_BITS:0] dxs, dys, dzs;

	logic res_valid_q, res_user_q;
	logic [263:0] res_data_q;

	logic take;
	assign take = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !res_valid_q;

	pve3d_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	always_comb begin
		mag_sel = mag_q[ax_q];
		vm_sel  = vmag_q[ax_q];
		prod    = 64'(mag_sel) * 64'(mag_sel);
		if (state_q == ST_VSQ) prod = 64'(vm_sel) * 64'(vm_sel);
		// launch the root on the last square of a pass
		sq_req.start    = (state_q == ST_SQ || state_q == ST_VSQ) && ax_q == 2'd2;
		sq_req.radicand = acc_q + SUM_BITS'(prod);
		dv_rem_sh = {dv_rem_q[STAMP_BITS-1:0], dv_num_q[NUM_BITS-1]};
		twice_rem = {dv_rem_q[STAMP_BITS-1:0], 1'b0};
		q_rnd = {1'b0, dv_quo_q} + {{NUM_BITS{1'b0}}, (twice_rem >= {1'b0, dt_q})};
		if (neg_q[ax_q])
			vel_sat = (q_rnd > 36'h80000000) ? 32'h80000000 : 32'(-q_rnd);
		else
			vel_sat = (q_rnd > 36'h7fffffff) ? 32'h7fffffff : q_rnd[31:0];
		dxs = {x_q[POS_BITS-1], x_q} - {last_x_q[POS_BITS-1], last_x_q};
		dys = {y_q[POS_BITS-1], y_q} - {last_y_q[POS_BITS-1], last_y_q};
		dzs = {z_q[POS_BITS-1], z_q} - {last_z_q[POS_BITS-1], last_z_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (take && !s_axis_tuser && has_prev_q &&
				s_axis_tdata[119:72] > last_stamp_q) state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_SQ;
			ST_SQ:    if (ax_q == 2'd2) state_d = ST_ROOT1;
			ST_ROOT1: if (sq_rsp.done) state_d = ST_DIV;
			ST_DIV:   if (cnt_q == CNT_BITS'(NUM_BITS) && ax_q == 2'd2) state_d = ST_VSQ;
			ST_VSQ:   if (ax_q == 2'd2) state_d = ST_ROOT2;
			ST_ROOT2: if (sq_rsp.done) state_d = ST_DONE;
			ST_DONE:  if (!res_valid_q) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_prev_q   <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			last_z_q     <= '0;
			last_stamp_q <= '0;
			res_valid_q  <= 1'b0;
			ax_q         <= '0;
			cnt_q        <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (take) begin
					x_q  <= s_axis_tdata[23:0];
					y_q  <= s_axis_tdata[47:24];
					z_q  <= s_axis_tdata[71:48];
					dt_q <= s_axis_tdata[119:72] - last_stamp_q;
					ax_q <= '0;
					acc_q <= '0;
					if (s_axis_tuser) begin
						// clear history
						has_prev_q <= 1'b0;
						last_x_q <= '0; last_y_q <= '0; last_z_q <= '0;
						last_stamp_q <= '0;
						res_valid_q <= 1'b1; res_user_q <= 1'b0; res_data_q <= '0;
					end else if (!has_prev_q || s_axis_tdata[119:72] <= last_stamp_q) begin
						// store fix only
						has_prev_q <= 1'b1;
						last_x_q <= s_axis_tdata[23:0];
						last_y_q <= s_axis_tdata[47:24];
						last_z_q <= s_axis_tdata[71:48];
						last_stamp_q <= s_axis_tdata[119:72];
						res_valid_q <= 1'b1; res_user_q <= 1'b0; res_data_q <= '0;
					end
				end
				ST_DIFF: begin
					mag_q[0] <= dxs[POS_BITS] ? DIFF_BITS'(-dxs) : DIFF_BITS'(dxs);
					mag_q[1] <= dys[POS_BITS] ? DIFF_BITS'(-dys) : DIFF_BITS'(dys);
					mag_q[2] <= dzs[POS_BITS] ? DIFF_BITS'(-dzs) : DIFF_BITS'(dzs);
					neg_q <= {dzs[POS_BITS], dys[POS_BITS], dxs[POS_BITS]};
				end
				ST_SQ, ST_VSQ: begin
					acc_q <= acc_q + SUM_BITS'(prod);
					ax_q  <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				end
				ST_ROOT1, ST_ROOT2: if (sq_rsp.done) begin
					acc_q <= '0;
					if (state_q == ST_ROOT1) begin
						disp_q <= (sq_rsp.root > 33'h1ffffff) ? 25'h1ffffff : sq_rsp.root[24:0];
						dv_num_q <= NUM_BITS'(mag_q[0]) * NUM_BITS'(SEC_MS);
						dv_rem_q <= '0; dv_quo_q <= '0;
					end else
						spd_q <= (sq_rsp.root > 33'hffffffff) ? 32'hffffffff
							: sq_rsp.root[31:0];
				end
				ST_DIV: begin
					if (cnt_q < CNT_BITS'(NUM_BITS)) begin
						dv_num_q <= {dv_num_q[NUM_BITS-2:0], 1'b0};
						if (dv_rem_sh >= {1'b0, dt_q}) begin
							dv_rem_q <= dv_rem_sh - {1'b0, dt_q};
							dv_quo_q <= {dv_quo_q[NUM_BITS-2:0], 1'b1};
						end else begin
							dv_rem_q <= dv_rem_sh;
							dv_quo_q <= {dv_quo_q[NUM_BITS-2:0], 1'b0};
						end
						cnt_q <= cnt_q + CNT_BITS'(1);
					end else begin
						vel_q[ax_q]  <= vel_sat;
						vmag_q[ax_q] <= vel_sat[31] ? 32'(-vel_sat) : vel_sat;
						cnt_q <= '0;
						dv_rem_q <= '0; dv_quo_q <= '0;
						ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
						dv_num_q <= NUM_BITS'(mag_q[(ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1])
							* NUM_BITS'(SEC_MS);
					end
				end
				ST_DONE: if (!res_valid_q) begin
					res_valid_q <= 1'b1;
					res_user_q  <= 1'b1;
					res_data_q  <= {7'd0, spd_q, vel_q[2], vel_q[1], vel_q[0], disp_q,
						(dt_q > 48'hffffffff) ? 32'hffffffff : dt_q[31:0], z_q, y_q, x_q};
					last_x_q <= x_q; last_y_q <= y_q; last_z_q <= z_q;
					last_stamp_q <= last_stamp_q + dt_q;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_data_q;
	assign m_axis_tuser  = res_user_q;
endmodule
